@@ sv/mpcl_pkg.sv @@
package mpcl_pkg;

    // fixed field widths
    localparam int LABEL_W = 8;
    localparam int FIDX_W  = 10;
    localparam int FCNT_W  = 11;
    localparam int CCNT_W  = 9;

    // configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 11;
    localparam logic [CFG_IW-1:0] REG_FACE_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] REG_CELL_COUNT = 2'd1;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // parameter defaults
    localparam int DEF_MAX_FACES  = 1024;
    localparam int DEF_MAX_CELLS  = 256;
    localparam int DEF_COORD_BITS = 18;

    // labels are 8 bits, so at most this many cells take part
    localparam int LABEL_LIMIT = 256;

    typedef struct packed {
        logic [LABEL_W-1:0] owner;
        logic               has_nb;
        logic [LABEL_W-1:0] nb;
    } t_link;

    typedef struct packed {
        logic               en;
        logic [LABEL_W-1:0] cell_id;
    } t_reject;

    typedef struct packed {
        logic               wr_en;
        logic               wr_val;
        logic [LABEL_W-1:0] wr_cell;
        logic               rd_en;
        logic [LABEL_W-1:0] rd_cell;
    } t_cell_cmd;

endpackage

@@ sv/mpcl_face_mem.sv @@
module mpcl_face_mem #(
    parameter int DEPTH = mpcl_pkg::DEF_MAX_FACES,
    parameter int AW    = 10,
    parameter int WIDTH = 89
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/mpcl_side_test.sv @@
module mpcl_side_test #(
    parameter int COORD_BITS = mpcl_pkg::DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_nx,
    input  logic signed [COORD_BITS-1:0] i_ny,
    input  mpcl_pkg::t_link              i_link,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic [mpcl_pkg::CCNT_W-1:0]  i_nc,
    output mpcl_pkg::t_reject            o_rej,
    output logic                         o_busy
);

    import mpcl_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 1;
    localparam int SW = PW + 1;

    // stage A: differences
    logic signed [DW-1:0]         n_dx, n_dy;
    logic signed [DW-1:0]         r_dx, r_dy;
    logic signed [COORD_BITS-1:0] r_nx, r_ny;
    logic                         r_zero_a;
    t_link                        r_link_a;
    logic                         r_va;

    // stage B: products
    logic signed [PW-1:0] r_p1, r_p2;
    logic                 r_zero_b;
    t_link                r_link_b;
    logic                 r_vb;

    logic signed [SW-1:0] sum;
    logic                 inner;

    assign n_dx = DW'(i_px) - DW'(i_cx);
    assign n_dy = DW'(i_py) - DW'(i_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_nx     <= i_nx;
        r_ny     <= i_ny;
        // zero offset or zero normal never counts as inner
        r_zero_a <= ((n_dx == '0) && (n_dy == '0)) || ((i_nx == '0) && (i_ny == '0));
        r_link_a <= i_link;

        r_p1     <= PW'(r_dx) * PW'(r_nx);
        r_p2     <= PW'(r_dy) * PW'(r_ny);
        r_zero_b <= r_zero_a;
        r_link_b <= r_link_a;
    end

    assign sum   = SW'(r_p1) + SW'(r_p2);
    assign inner = !r_zero_b && (sum[SW-1] || (sum == '0));

    always_comb begin
        if (!inner) begin
            o_rej.en      = r_vb && (CCNT_W'(r_link_b.owner) < i_nc);
            o_rej.cell_id = r_link_b.owner;
        end else begin
            o_rej.en      = r_vb && r_link_b.has_nb && (CCNT_W'(r_link_b.nb) < i_nc);
            o_rej.cell_id = r_link_b.nb;
        end
    end

    assign o_busy = r_va || r_vb;

endmodule

@@ sv/mpcl_reject_mem.sv @@
module mpcl_reject_mem #(
    parameter int DEPTH = mpcl_pkg::LABEL_LIMIT,
    parameter int AW    = 8
) (
    input  logic                i_clk,
    input  mpcl_pkg::t_cell_cmd i_cmd,
    output logic                o_rdata
);

    import mpcl_pkg::*;

    logic mem [DEPTH];
    logic r_rdata;

    // read returns the old entry when the same cell is written that cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[AW'(i_cmd.wr_cell)] <= i_cmd.wr_val;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[AW'(i_cmd.rd_cell)];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/mesh_point_cell_location.sv @@
// Point location in a 2D face-normal mesh. A start with op = load writes one
// face entry and returns nothing; busy stays low. A start with op = query
// walks faces 0..nf-1 (nf = face_count capped at MAX_FACES) through the single
// read port of the face memory, one face per cycle, then scans the
// rejected-cell memory over cells 0..nc-1 (nc = cell_count capped at
// min(MAX_CELLS, 256)), one cell per cycle, clearing each entry as it goes.
// Busy is high from the start transfer to the result strobe and drops in the
// strobe cycle, so the next start can be taken at the edge that ends it.
// The result is shown for exactly one cycle on o_result_valid and cannot be
// held off, so the receiver must take it then. After reset the block runs a
// clearing pass over all min(MAX_CELLS, 256) entries of the rejected-cell
// memory with busy high; configuration writes are taken at any time but only
// belong while idle.
module mesh_point_cell_location #(
    parameter int MAX_FACES  = mpcl_pkg::DEF_MAX_FACES,
    parameter int MAX_CELLS  = mpcl_pkg::DEF_MAX_CELLS,
    parameter int COORD_BITS = mpcl_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [mpcl_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [mpcl_pkg::CFG_DW-1:0]   i_cfg_data,
    // command
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [mpcl_pkg::FIDX_W-1:0]   i_face_index,
    input  logic signed [COORD_BITS-1:0]  i_centre_x,
    input  logic signed [COORD_BITS-1:0]  i_centre_y,
    input  logic signed [COORD_BITS-1:0]  i_normal_x,
    input  logic signed [COORD_BITS-1:0]  i_normal_y,
    input  logic [mpcl_pkg::LABEL_W-1:0]  i_owner_cell,
    input  logic [mpcl_pkg::LABEL_W-1:0]  i_neighbour_cell,
    input  logic                          i_has_neighbour,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    // result
    output logic                          o_result_valid,
    output logic                          o_cell_found,
    output logic [mpcl_pkg::LABEL_W-1:0]  o_cell_label
);

    import mpcl_pkg::*;

    // face memory geometry
    localparam int FACE_AW = $clog2(MAX_FACES);
    localparam int FACE_CW = $clog2(MAX_FACES + 1);
    localparam int GEO_W   = 4 * COORD_BITS;
    localparam int FACE_W  = GEO_W + $bits(t_link);

    // only labels 0..255 take part in a query
    localparam int CELL_DEPTH = (MAX_CELLS < LABEL_LIMIT) ? MAX_CELLS : LABEL_LIMIT;
    localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

    // sequencer states
    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_WALK     = 3'd2;
    localparam logic [2:0] ST_DRAIN    = 3'd3;
    localparam logic [2:0] ST_SCAN     = 3'd4;
    localparam logic [2:0] ST_SCAN_END = 3'd5;

    logic [2:0] r_state, n_state;

    // configuration registers
    logic [FCNT_W-1:0] r_face_count;
    logic [CCNT_W-1:0] r_cell_count;

    // per-query context
    logic [FACE_CW-1:0]           r_nf, n_nf;
    logic [CCNT_W-1:0]            r_nc, n_nc;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [FACE_CW-1:0]           r_face_cnt, n_face_cnt;
    logic [CCNT_W-1:0]            r_cell_cnt, n_cell_cnt;
    logic                         r_rd_v, n_rd_v;
    logic                         r_scan_v, n_scan_v;
    logic [LABEL_W-1:0]           r_scan_cell, n_scan_cell;
    logic                         r_found, n_found;
    logic [LABEL_W-1:0]           r_label, n_label;
    logic                         r_res_v, n_res_v;

    logic accept, load_we;
    logic [FACE_W-1:0] face_wdata, face_rdata;
    logic [FACE_AW-1:0] face_waddr;
    t_link     rd_link, wr_link;
    t_reject   rej;
    t_cell_cmd cell_cmd;
    logic      side_busy;
    logic      rej_rdata;
    logic signed [COORD_BITS-1:0] rd_cx, rd_cy, rd_nx, rd_ny;

    assign accept  = start && !busy;
    assign load_we = accept && (i_op == OP_LOAD) && (32'(i_face_index) < MAX_FACES);

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_count <= '0;
            r_cell_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FACE_COUNT: r_face_count <= FCNT_W'(i_cfg_data);
                REG_CELL_COUNT: r_cell_count <= CCNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // face entry packing: centre x, centre y, normal x, normal y, link
    assign wr_link.owner  = i_owner_cell;
    assign wr_link.has_nb = i_has_neighbour;
    assign wr_link.nb     = i_neighbour_cell;
    assign face_wdata = {i_centre_x, i_centre_y, i_normal_x, i_normal_y, wr_link};
    assign face_waddr = FACE_AW'(i_face_index);

    assign rd_cx   = face_rdata[FACE_W-1 -: COORD_BITS];
    assign rd_cy   = face_rdata[FACE_W-1-COORD_BITS -: COORD_BITS];
    assign rd_nx   = face_rdata[FACE_W-1-2*COORD_BITS -: COORD_BITS];
    assign rd_ny   = face_rdata[FACE_W-1-3*COORD_BITS -: COORD_BITS];
    assign rd_link = face_rdata[$bits(t_link)-1:0];

    mpcl_face_mem #(
        .DEPTH (MAX_FACES),
        .AW    (FACE_AW),
        .WIDTH (FACE_W)
    ) u_face_mem (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (face_waddr),
        .i_wdata (face_wdata),
        .i_re    (n_rd_v),
        .i_raddr (r_face_cnt[FACE_AW-1:0]),
        .o_rdata (face_rdata)
    );

    mpcl_side_test #(
        .COORD_BITS (COORD_BITS)
    ) u_side_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_v),
        .i_cx    (rd_cx),
        .i_cy    (rd_cy),
        .i_nx    (rd_nx),
        .i_ny    (rd_ny),
        .i_link  (rd_link),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_nc    (r_nc),
        .o_rej   (rej),
        .o_busy  (side_busy)
    );

    mpcl_reject_mem #(
        .DEPTH (CELL_DEPTH),
        .AW    (CELL_AW)
    ) u_reject_mem (
        .i_clk   (i_clk),
        .i_cmd   (cell_cmd),
        .o_rdata (rej_rdata)
    );

    // rejected-cell memory access: clear sweep, face rejections, scan with clear
    always_comb begin
        cell_cmd = '0;
        unique case (r_state)
            ST_CLEAR: begin
                cell_cmd.wr_en   = 1'b1;
                cell_cmd.wr_cell = r_cell_cnt[LABEL_W-1:0];
            end
            ST_SCAN: begin
                cell_cmd.wr_en   = n_scan_v;
                cell_cmd.wr_cell = r_cell_cnt[LABEL_W-1:0];
                cell_cmd.rd_en   = n_scan_v;
                cell_cmd.rd_cell = r_cell_cnt[LABEL_W-1:0];
            end
            default: begin
                cell_cmd.wr_en   = rej.en;
                cell_cmd.wr_val  = 1'b1;
                cell_cmd.wr_cell = rej.cell_id;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_nf        = r_nf;
        n_nc        = r_nc;
        n_face_cnt  = r_face_cnt;
        n_cell_cnt  = r_cell_cnt;
        n_rd_v      = 1'b0;
        n_scan_v    = 1'b0;
        n_scan_cell = r_cell_cnt[LABEL_W-1:0];
        n_found     = r_found;
        n_label     = r_label;
        n_res_v     = 1'b0;

        // scan data comes back in the cycle after its read; first clear cell wins
        if (r_scan_v && !r_found && !rej_rdata) begin
            n_found = 1'b1;
            n_label = r_scan_cell;
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_cell_cnt = r_cell_cnt + 1'b1;
                if (32'(r_cell_cnt) == CELL_DEPTH - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (i_op == OP_QUERY)) begin
                    n_nf = (32'(r_face_count) > MAX_FACES) ? FACE_CW'(MAX_FACES)
                                                            : FACE_CW'(r_face_count);
                    n_nc = (32'(r_cell_count) > CELL_DEPTH) ? CCNT_W'(CELL_DEPTH)
                                                             : r_cell_count;
                    n_face_cnt = '0;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_face_cnt < r_nf) begin
                    n_rd_v     = 1'b1;
                    n_face_cnt = r_face_cnt + 1'b1;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // every rejection must land before the scan reads
                if (!r_rd_v && !side_busy) begin
                    n_cell_cnt = '0;
                    n_found    = 1'b0;
                    n_label    = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cell_cnt < r_nc) begin
                    n_scan_v   = 1'b1;
                    n_cell_cnt = r_cell_cnt + 1'b1;
                end else begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                if (!r_scan_v) begin
                    n_res_v = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cell_cnt <= '0;
            r_face_cnt <= '0;
            r_rd_v     <= 1'b0;
            r_scan_v   <= 1'b0;
            r_res_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cell_cnt <= n_cell_cnt;
            r_face_cnt <= n_face_cnt;
            r_rd_v     <= n_rd_v;
            r_scan_v   <= n_scan_v;
            r_res_v    <= n_res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nf        <= n_nf;
        r_nc        <= n_nc;
        r_scan_cell <= n_scan_cell;
        r_found     <= n_found;
        r_label     <= n_label;
        if (accept && (i_op == OP_QUERY)) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_res_v;
    assign o_cell_found   = r_found;
    assign o_cell_label   = r_label;

    // checks
    a_no_result_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!r_rd_v && !side_busy && !r_scan_v))
        else $error("result strobe while face or scan data in flight");

    a_reject_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rej.en |-> ((r_state == ST_WALK) || (r_state == ST_DRAIN)))
        else $error("cell rejection outside the face walk");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cell_cnt <= r_nc))
        else $error("scan counter past cell count");

endmodule

@@ tb/sv/tb_mesh_point_cell_location.sv @@
`timescale 1ns / 100ps

module tb_mesh_point_cell_location;
    import mpcl_pkg::*;

    localparam int CB       = DEF_COORD_BITS;
    localparam int N_FACES  = DEF_MAX_FACES;
    // labels are 8 bits wide, so at most 256 cells ever take part
    localparam int N_CELLS  = (DEF_MAX_CELLS < LABEL_LIMIT) ? DEF_MAX_CELLS : LABEL_LIMIT;
    localparam int MAXC     = (1 << (CB - 1)) - 1;
    localparam int MINC     = -(1 << (CB - 1));
    localparam int RANDOM_ITEMS   = 300;
    // faces loaded and walked by the large-table phase
    localparam int LARGE_FACES    = 256;
    // worst query: every face, every cell, plus pipeline overhead
    localparam int TAIL_CYCLES    = N_FACES + N_CELLS + 16;
    // no transfer for this long means the block hung
    localparam int WATCHDOG_LIMIT = 8000;

    // one command item as the block's ports see it
    typedef struct packed {
        logic                     op;
        logic [FIDX_W-1:0]        face_index;
        logic signed [CB-1:0]     centre_x;
        logic signed [CB-1:0]     centre_y;
        logic signed [CB-1:0]     normal_x;
        logic signed [CB-1:0]     normal_y;
        logic [LABEL_W-1:0]       owner;
        logic [LABEL_W-1:0]       nb;
        logic                     has_nb;
        logic signed [CB-1:0]     point_x;
        logic signed [CB-1:0]     point_y;
    } t_mesh_cmd;

    typedef struct packed {
        logic               found;
        logic [LABEL_W-1:0] lbl;
    } t_locate_result;

    // Keeps a private copy of the face table and the two count registers,
    // predicts the containing cell of every accepted query and compares it
    // with the strobed result in order.
    class cell_locator_sb;
        int fail_count;
        int found_count;
        int outside_count;
        logic [FCNT_W-1:0]    face_count_reg;
        logic [CCNT_W-1:0]    cell_count_reg;
        logic signed [CB-1:0] cx_tab [N_FACES];
        logic signed [CB-1:0] cy_tab [N_FACES];
        logic signed [CB-1:0] nx_tab [N_FACES];
        logic signed [CB-1:0] ny_tab [N_FACES];
        t_link                link_tab [N_FACES];
        t_locate_result       pending [$];

        function new();
            fail_count     = 0;
            found_count    = 0;
            outside_count  = 0;
            face_count_reg = '0;
            cell_count_reg = '0;
        endfunction

        task report(string what);
            fail_count++;
            $display("ERROR at %0t: %s", $time, what);
        endtask

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                REG_FACE_COUNT: face_count_reg = val[FCNT_W-1:0];
                REG_CELL_COUNT: cell_count_reg = val[CCNT_W-1:0];
                default: ;
            endcase
        endfunction

        // exact sign of (p - centre) . normal; a zero vector never counts
        function bit inner_side(int f, logic signed [CB-1:0] px, logic signed [CB-1:0] py);
            longint dx, dy, vx, vy;
            dx = longint'(px) - longint'(cx_tab[f]);
            dy = longint'(py) - longint'(cy_tab[f]);
            vx = longint'(nx_tab[f]);
            vy = longint'(ny_tab[f]);
            if ((dx == 0 && dy == 0) || (vx == 0 && vy == 0))
                return 1'b0;
            return (dx * vx + dy * vy) <= 0;
        endfunction

        function t_locate_result locate(logic signed [CB-1:0] px, logic signed [CB-1:0] py);
            t_locate_result r;
            bit rejected [N_CELLS];
            int nf, nc, f, k;
            bit inner;
            nf = (int'(face_count_reg) > N_FACES) ? N_FACES : int'(face_count_reg);
            nc = (int'(cell_count_reg) > N_CELLS) ? N_CELLS : int'(cell_count_reg);
            for (k = 0; k < N_CELLS; k++)
                rejected[k] = 1'b0;
            for (f = 0; f < nf; f++) begin
                inner = inner_side(f, px, py);
                // labels outside 0..nc-1 still get tested, their rejection is dropped
                if (!inner && int'(link_tab[f].owner) < nc)
                    rejected[link_tab[f].owner] = 1'b1;
                if (link_tab[f].has_nb && inner && int'(link_tab[f].nb) < nc)
                    rejected[link_tab[f].nb] = 1'b1;
            end
            r = '0;
            for (k = 0; k < nc; k++) begin
                if (!rejected[k]) begin
                    r.found = 1'b1;
                    r.lbl   = LABEL_W'(k);
                    break;
                end
            end
            return r;
        endfunction

        // an accepted start transfer: loads update the table, queries expect one result
        function void note_transfer(t_mesh_cmd c);
            if (c.op == OP_LOAD) begin
                cx_tab[c.face_index]   = c.centre_x;
                cy_tab[c.face_index]   = c.centre_y;
                nx_tab[c.face_index]   = c.normal_x;
                ny_tab[c.face_index]   = c.normal_y;
                link_tab[c.face_index] = '{owner: c.owner, has_nb: c.has_nb, nb: c.nb};
            end else begin
                pending.insert(pending.size(), locate(c.point_x, c.point_y));
            end
        endfunction

        task check_result(logic found, logic [LABEL_W-1:0] lbl);
            t_locate_result want;
            if (pending.size() == 0) begin
                report($sformatf("result strobe with no query waiting (found %b label %0d)",
                                 found, lbl));
            end else begin
                want = pending.pop_front();
                if (found !== want.found)
                    report($sformatf("cell_found is %b, want %b", found, want.found));
                if (lbl !== want.lbl)
                    report($sformatf("cell_label is %0d, want %0d", lbl, want.lbl));
                if (want.found)
                    found_count++;
                else
                    outside_count++;
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IW-1:0]     i_cfg_index;
    logic [CFG_DW-1:0]     i_cfg_data;
    logic                  start;
    logic                  busy;
    logic                  i_op;
    logic [FIDX_W-1:0]     i_face_index;
    logic signed [CB-1:0]  i_centre_x;
    logic signed [CB-1:0]  i_centre_y;
    logic signed [CB-1:0]  i_normal_x;
    logic signed [CB-1:0]  i_normal_y;
    logic [LABEL_W-1:0]    i_owner_cell;
    logic [LABEL_W-1:0]    i_neighbour_cell;
    logic                  i_has_neighbour;
    logic signed [CB-1:0]  i_point_x;
    logic signed [CB-1:0]  i_point_y;
    logic                  o_result_valid;
    logic                  o_cell_found;
    logic [LABEL_W-1:0]    o_cell_label;

    cell_locator_sb sb = new();

    int  n_loads   = 0;
    int  n_queries = 0;
    int  n_phases  = 0;
    int  stall_cycles = 0;
    bit  no_idle   = 1'b0;   // phase-wide switch: back-to-back transfers

    mesh_point_cell_location i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_face_index     (i_face_index),
        .i_centre_x       (i_centre_x),
        .i_centre_y       (i_centre_y),
        .i_normal_x       (i_normal_x),
        .i_normal_y       (i_normal_y),
        .i_owner_cell     (i_owner_cell),
        .i_neighbour_cell (i_neighbour_cell),
        .i_has_neighbour  (i_has_neighbour),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .o_result_valid   (o_result_valid),
        .o_cell_found     (o_cell_found),
        .o_cell_label     (o_cell_label)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results cannot be held off: every strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_cell_found, o_cell_label);
    end

    // Watchdog: counts edges with neither a start transfer nor a result strobe.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, sb.pending.size());
            $display("simulation failed");
            $finish;
        end
    end

    // every field random; callers then overwrite what matters
    function automatic t_mesh_cmd rand_cmd();
        t_mesh_cmd c;
        c.op         = 1'($urandom);
        c.face_index = FIDX_W'($urandom);
        c.centre_x   = CB'($urandom);
        c.centre_y   = CB'($urandom);
        c.normal_x   = CB'($urandom);
        c.normal_y   = CB'($urandom);
        c.owner      = LABEL_W'($urandom);
        c.nb         = LABEL_W'($urandom);
        c.has_nb     = 1'($urandom);
        c.point_x    = CB'($urandom);
        c.point_y    = CB'($urandom);
        return c;
    endfunction

    function automatic t_mesh_cmd query_at(int px, int py);
        t_mesh_cmd c;
        c         = rand_cmd();
        c.op      = OP_QUERY;
        c.point_x = CB'(px);
        c.point_y = CB'(py);
        return c;
    endfunction

    function automatic t_mesh_cmd face_load(int idx, int cx, int cy, int nx, int ny,
                                            int own, int has, int nbl);
        t_mesh_cmd c;
        c            = rand_cmd();
        c.op         = OP_LOAD;
        c.face_index = FIDX_W'(idx);
        c.centre_x   = CB'(cx);
        c.centre_y   = CB'(cy);
        c.normal_x   = CB'(nx);
        c.normal_y   = CB'(ny);
        c.owner      = LABEL_W'(own);
        c.has_nb     = 1'(has);
        c.nb         = LABEL_W'(nbl);
        return c;
    endfunction

    // One start transfer. Inputs move on the falling edge; the transfer is
    // taken at the first rising edge with busy low. start stays high into the
    // next item when no gap is drawn.
    task automatic issue(t_mesh_cmd c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op             = c.op;
        i_face_index     = c.face_index;
        i_centre_x       = c.centre_x;
        i_centre_y       = c.centre_y;
        i_normal_x       = c.normal_x;
        i_normal_y       = c.normal_y;
        i_owner_cell     = c.owner;
        i_neighbour_cell = c.nb;
        i_has_neighbour  = c.has_nb;
        i_point_x        = c.point_x;
        i_point_y        = c.point_y;
        start            = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_transfer(c);
        if (c.op == OP_LOAD)
            n_loads++;
        else
            n_queries++;
    endtask

    // Drop start and wait for the block to drain: no query outstanding and
    // busy low. Loads never raise busy, so a few extra cycles cover them.
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending.size() != 0 || busy)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // only called while idle
    task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_DW'(val);
        sb.set_reg(idx, CFG_DW'(val));
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Hand-built cases: empty mesh, faceless cells, one unit square with a
    // right neighbour, a zero normal, a point on a face centre, a point on a
    // face line, labels outside the cell range and full-scale coordinates.
    task automatic run_directed();
        write_reg(REG_FACE_COUNT, 0);
        write_reg(REG_CELL_COUNT, 0);
        issue(query_at(MAXC, MAXC));            // no cells at all -> outside
        settle();
        write_reg(REG_CELL_COUNT, 3);
        issue(query_at(MINC, MINC));            // no faces -> cell 0 passes
        // unit square (1.0 = 1024) owned by cell 0, right face shared with cell 1
        issue(face_load(0, 1024, 512, 1024, 0, 0, 1, 1));
        issue(face_load(1, 0, 512, -1024, 0, 0, 0, 0));
        issue(face_load(2, 512, 1024, 0, 1024, 0, 0, 0));
        issue(face_load(3, 512, 0, 0, -1024, 0, 0, 0));
        issue(face_load(4, 300, 300, 0, 0, 2, 0, 0));          // zero normal: cell 2 always out
        issue(face_load(5, MAXC, MINC, MINC, MAXC, 255, 1, 255)); // labels beyond cell_count
        issue(face_load(N_FACES - 1, MINC, MAXC, MAXC, MINC, 128, 1, 127));
        settle();
        write_reg(REG_FACE_COUNT, 6);
        issue(query_at(512, 512));              // inside the square
        issue(query_at(1024, 512));             // on the shared face centre
        issue(query_at(1024, 700));             // on the shared face line
        issue(query_at(2000, 512));             // right of the square
        issue(query_at(MINC, MAXC));            // largest products
        issue(query_at(MAXC, MINC));            // centre of the full-scale face
        issue(query_at(MAXC, MAXC));
    endtask

    // A random structured grid mesh, cols x rows rectangular cells, with
    // internal faces in random orientation, optional junk faces after it,
    // then queries mostly inside or on the grid plus some noise.
    task automatic run_mesh_phase();
        t_mesh_cmd faces [$];
        t_mesh_cmd c;
        int cols, rows, w, h, ox, oy, s, i, j, k, q, r;
        int n_cells, nf, nc, n_q, px, py;
        cols = $urandom_range(1, 4);
        rows = $urandom_range(1, 4);
        w    = $urandom_range(64, 8000);
        h    = $urandom_range(64, 8000);
        ox   = int'($urandom_range(0, 80000)) - 60000;
        oy   = int'($urandom_range(0, 80000)) - 60000;
        n_cells = cols * rows;
        no_idle = ($urandom_range(0, 3) == 0);

        // vertical faces, normal along x
        for (j = 0; j < rows; j++) begin
            for (i = 0; i <= cols; i++) begin
                s = $urandom_range(1, MAXC);
                if (i == 0)
                    c = face_load(faces.size(), ox, oy + j * h + h / 2, -s, 0, j * cols, 0, 0);
                else if (i == cols)
                    c = face_load(faces.size(), ox + i * w, oy + j * h + h / 2, s, 0,
                                  j * cols + cols - 1, 0, 0);
                else if ($urandom_range(0, 1))
                    c = face_load(faces.size(), ox + i * w, oy + j * h + h / 2, s, 0,
                                  j * cols + i - 1, 1, j * cols + i);
                else
                    c = face_load(faces.size(), ox + i * w, oy + j * h + h / 2, -s, 0,
                                  j * cols + i, 1, j * cols + i - 1);
                if (i == 0 || i == cols)
                    c.nb = LABEL_W'($urandom);  // unused on boundary faces
                faces.insert(faces.size(), c);
            end
        end
        // horizontal faces, normal along y
        for (j = 0; j <= rows; j++) begin
            for (i = 0; i < cols; i++) begin
                s = $urandom_range(1, MAXC);
                if (j == 0)
                    c = face_load(faces.size(), ox + i * w + w / 2, oy, 0, -s, i, 0, 0);
                else if (j == rows)
                    c = face_load(faces.size(), ox + i * w + w / 2, oy + j * h, 0, s,
                                  (rows - 1) * cols + i, 0, 0);
                else if ($urandom_range(0, 1))
                    c = face_load(faces.size(), ox + i * w + w / 2, oy + j * h, 0, s,
                                  (j - 1) * cols + i, 1, j * cols + i);
                else
                    c = face_load(faces.size(), ox + i * w + w / 2, oy + j * h, 0, -s,
                                  j * cols + i, 1, (j - 1) * cols + i);
                if (j == 0 || j == rows)
                    c.nb = LABEL_W'($urandom);
                faces.insert(faces.size(), c);
            end
        end
        // junk faces with random geometry, about half of them with nearby labels
        if ($urandom_range(0, 9) < 3) begin
            for (k = $urandom_range(1, 3); k > 0; k--) begin
                c            = rand_cmd();
                c.op         = OP_LOAD;
                c.face_index = FIDX_W'(faces.size());
                if ($urandom_range(0, 1)) begin
                    c.owner = LABEL_W'($urandom_range(0, n_cells + 2));
                    c.nb    = LABEL_W'($urandom_range(0, n_cells + 2));
                end
                faces.insert(faces.size(), c);
            end
        end

        // walk all loaded faces mostly, sometimes only a prefix
        nf = ($urandom_range(0, 99) < 85) ? faces.size() : $urandom_range(0, faces.size());
        case ($urandom_range(0, 9))
            0:       nc = $urandom_range(0, n_cells - 1);       // some owners out of range
            1, 2:    nc = n_cells + $urandom_range(1, 4);       // faceless cells on top
            default: nc = n_cells;
        endcase
        settle();
        write_reg(REG_FACE_COUNT, nf);
        write_reg(REG_CELL_COUNT, nc);
        foreach (faces[k])
            issue(faces[k]);

        n_q = $urandom_range(6, 16);
        for (q = 0; q < n_q; q++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // corrupt a face in place, or write anywhere in the table
                c    = rand_cmd();
                c.op = OP_LOAD;
                if ($urandom_range(0, 1))
                    c.face_index = FIDX_W'($urandom_range(0, faces.size() - 1));
                issue(c);
            end else if (r < 13) begin
                c    = rand_cmd();
                c.op = OP_QUERY;
                issue(c);
            end else if (r < 28) begin
                // on a face: its centre exactly, or slid along the face line
                k  = $urandom_range(0, faces.size() - 1);
                px = int'(faces[k].centre_x);
                py = int'(faces[k].centre_y);
                if ($urandom_range(0, 1)) begin
                    if (faces[k].normal_y == 0 && faces[k].normal_x != 0)
                        py = py + $urandom_range(0, h) - h / 2;
                    else if (faces[k].normal_x == 0 && faces[k].normal_y != 0)
                        px = px + $urandom_range(0, w) - w / 2;
                end
                issue(query_at(px, py));
            end else begin
                // over the grid, with a margin of half a cell around it
                px = ox - w / 2 + $urandom_range(0, cols * w + w);
                py = oy - h / 2 + $urandom_range(0, rows * h + h);
                issue(query_at(px, py));
            end
        end
        n_phases++;
    endtask

    // Fill a large block of the table, then walk it with every cell taking
    // part, first at the nominal cell maximum and then at the saturating
    // all-ones cell count.
    task automatic run_large_table();
        t_mesh_cmd c;
        int f, q;
        no_idle = 1'b0;
        settle();
        for (f = 0; f < LARGE_FACES; f++) begin
            c            = rand_cmd();
            c.op         = OP_LOAD;
            c.face_index = FIDX_W'(f);
            if (f == LARGE_FACES - 2)
                c = face_load(f, MINC, MINC, MAXC, MAXC, 0, 1, 255);
            else if (f == LARGE_FACES - 1)
                c = face_load(f, MAXC, MAXC, MINC, MINC, 255, 1, 0);
            issue(c);
        end
        settle();
        write_reg(REG_FACE_COUNT, LARGE_FACES);
        write_reg(REG_CELL_COUNT, N_CELLS);
        for (q = 0; q < 3; q++)
            issue(query_at(int'($urandom_range(0, 2 * MAXC + 1)) + MINC,
                           int'($urandom_range(0, 2 * MAXC + 1)) + MINC));
        settle();
        write_reg(REG_CELL_COUNT, (1 << CCNT_W) - 1);
        issue(query_at(MINC, MAXC));
        issue(query_at(MAXC, MINC));
        issue(query_at(0, 0));
    endtask

    initial begin
        int directed_items;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        start            = 1'b0;
        i_op             = OP_LOAD;
        i_face_index     = '0;
        i_centre_x       = '0;
        i_centre_y       = '0;
        i_normal_x       = '0;
        i_normal_y       = '0;
        i_owner_cell     = '0;
        i_neighbour_cell = '0;
        i_has_neighbour  = 1'b0;
        i_point_x        = '0;
        i_point_y        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // the clearing pass after reset keeps busy high for a while
        settle();
        run_directed();
        directed_items = n_loads + n_queries;
        while (n_loads + n_queries - directed_items < RANDOM_ITEMS)
            run_mesh_phase();
        run_large_table();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d query results never arrived", sb.pending.size()));

        $display("run covered %0d face loads and %0d queries over %0d grid meshes plus a large table",
                 n_loads, n_queries, n_phases);
        $display("queries located: %0d inside a cell, %0d outside; %0d mismatches",
                 sb.found_count, sb.outside_count, sb.fail_count);
        if (sb.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ mesh_point_cell_location.f @@
sv/mpcl_pkg.sv
sv/mpcl_face_mem.sv
sv/mpcl_side_test.sv
sv/mpcl_reject_mem.sv
sv/mesh_point_cell_location.sv
tb/sv/tb_mesh_point_cell_location.sv
